// ===== sv/pdc_pkg.sv =====
package pdc_pkg;

    // Framing bytes and CRC polynomial
    localparam logic [7:0]  START_SHORT = 8'h02;
    localparam logic [7:0]  START_LONG  = 8'h03;
    localparam logic [7:0]  STOP_BYTE   = 8'h03;
    localparam logic [15:0] CRC_POLY    = 16'h1021;

    // Frame phase, one-hot
    typedef enum logic [7:0] {
        PH_HUNT    = 8'b0000_0001,
        PH_LEN_ONE = 8'b0000_0010,
        PH_LEN_HI  = 8'b0000_0100,
        PH_LEN_LO  = 8'b0000_1000,
        PH_PAYLOAD = 8'b0001_0000,
        PH_CRC_HI  = 8'b0010_0000,
        PH_CRC_LO  = 8'b0100_0000,
        PH_STOP    = 8'b1000_0000
    } t_phase;

    // Verdict codes
    typedef enum logic [1:0] {
        ST_GOOD     = 2'd0,
        ST_CRC_BAD  = 2'd1,
        ST_STOP_BAD = 2'd2
    } t_status;

    // One result item
    typedef struct packed {
        logic        is_verdict;
        logic [7:0]  payload_byte;
        logic [15:0] payload_index;
        t_status     frame_status;
        logic [15:0] received_check;
        logic [15:0] computed_check;
        logic [15:0] frame_length;
    } t_result;

    // Advance a CRC-16 (MSB first, no reflection) by one byte
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (crc[15]) begin
                crc = {crc[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc = {crc[14:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

// ===== sv/pdc_if.sv =====
// Byte input channel
interface pdc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       flush;

    modport source (output valid, output rx_byte, output flush, input ready);
    modport sink   (input valid, input rx_byte, input flush, output ready);
endinterface

// Result channel
interface pdc_out_if;
    logic        valid;
    logic        ready;
    logic        is_verdict;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic [1:0]  frame_status;
    logic [15:0] received_check;
    logic [15:0] computed_check;
    logic [15:0] frame_length;

    modport source (output valid, output is_verdict, output payload_byte,
                    output payload_index, output frame_status, output received_check,
                    output computed_check, output frame_length, input ready);
    modport sink   (input valid, input is_verdict, input payload_byte,
                    input payload_index, input frame_status, input received_check,
                    input computed_check, input frame_length, output ready);
endinterface

// ===== sv/packet_deframer_crc16.sv =====
// Channel   Dir  Fields                                           Transfer when
// i_rx      in   rx_byte[7:0] flush                               valid & ready
// o_res     out  is_verdict payload_byte payload_index            valid & ready
//                frame_status received_check computed_check frame_length
//
// One byte per cycle sustained while the output buffer has room: a byte is held
// in the input register while the frame logic and one CRC-16 byte update produce
// its result. Results queue in a two-entry output buffer; a byte passes the input
// register and its result is then written into the buffer before it is offered.
// Reset (synchronous, active low) returns to hunting with all counters and
// checks at zero. A stalled result side holds bytes back only once both
// buffer entries are full.
module packet_deframer_crc16
    import pdc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    pdc_in_if.sink    i_rx,
    pdc_out_if.source o_res
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_flush;
    logic       buf_ready;
    logic       fire;
    logic       res_valid;
    t_result    res;

    assign fire       = r_in_valid && buf_ready;
    assign i_rx.ready = !r_in_valid || fire;

    // Input register: take a byte whenever the stage frees up
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.ready && i_rx.valid) begin
            r_in_byte  <= i_rx.rx_byte;
            r_in_flush <= i_rx.flush;
        end
    end

    pdc_frame u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_byte      (r_in_byte),
        .i_flush     (r_in_flush),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    pdc_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .o_ready (buf_ready),
        .o_res   (o_res)
    );

endmodule

// ===== sv/pdc_frame.sv =====
module pdc_frame
    import pdc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_byte,
    input  logic       i_flush,
    output logic       o_res_valid,
    output t_result    o_res
);

    t_phase      r_phase,   n_phase;
    logic [15:0] r_len,     n_len;
    logic [15:0] r_taken,   n_taken;
    logic [15:0] r_crc,     n_crc;
    logic [15:0] r_carried, n_carried;
    logic [15:0] len_lo;

    assign len_lo = {r_len[15:8], i_byte};

    // Work out next frame state and the result for this byte
    always_comb begin
        n_phase     = r_phase;
        n_len       = r_len;
        n_taken     = r_taken;
        n_crc       = r_crc;
        n_carried   = r_carried;
        o_res       = '0;
        o_res_valid = 1'b0;
        if (i_flush) begin
            n_phase   = PH_HUNT;
            n_len     = '0;
            n_taken   = '0;
            n_crc     = '0;
            n_carried = '0;
        end else begin
            case (r_phase)
                PH_HUNT: begin
                    if (i_byte == START_SHORT) begin
                        n_phase = PH_LEN_ONE;
                    end else if (i_byte == START_LONG) begin
                        n_phase = PH_LEN_HI;
                    end
                end
                PH_LEN_ONE: begin
                    n_len   = {8'h00, i_byte};
                    n_taken = '0;
                    n_crc   = '0;
                    n_phase = (i_byte == 8'h00) ? PH_CRC_HI : PH_PAYLOAD;
                end
                PH_LEN_HI: begin
                    n_len   = {i_byte, 8'h00};
                    n_phase = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    n_len   = len_lo;
                    n_taken = '0;
                    n_crc   = '0;
                    n_phase = (len_lo == 16'h0000) ? PH_CRC_HI : PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    o_res_valid         = i_fire;
                    o_res.payload_byte  = i_byte;
                    o_res.payload_index = r_taken;
                    o_res.frame_length  = r_len;
                    n_crc               = crc16_byte(r_crc, i_byte);
                    n_taken             = r_taken + 16'd1;
                    if (n_taken == r_len) begin
                        n_phase = PH_CRC_HI;
                    end
                end
                PH_CRC_HI: begin
                    n_carried = {i_byte, 8'h00};
                    n_phase   = PH_CRC_LO;
                end
                PH_CRC_LO: begin
                    n_carried = {r_carried[15:8], i_byte};
                    n_phase   = PH_STOP;
                end
                PH_STOP: begin
                    o_res_valid          = i_fire;
                    o_res.is_verdict     = 1'b1;
                    o_res.received_check = r_carried;
                    o_res.computed_check = r_crc;
                    o_res.frame_length   = r_len;
                    if (i_byte != STOP_BYTE) begin
                        o_res.frame_status = ST_STOP_BAD;
                    end else if (r_carried != r_crc) begin
                        o_res.frame_status = ST_CRC_BAD;
                    end else begin
                        o_res.frame_status = ST_GOOD;
                    end
                    n_phase   = PH_HUNT;
                    n_len     = '0;
                    n_taken   = '0;
                    n_crc     = '0;
                    n_carried = '0;
                end
                default: begin
                    n_phase   = PH_HUNT;
                    n_len     = '0;
                    n_taken   = '0;
                    n_crc     = '0;
                    n_carried = '0;
                end
            endcase
        end
    end

    // Advance frame state on each processed byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT;
            r_len     <= '0;
            r_taken   <= '0;
            r_crc     <= '0;
            r_carried <= '0;
        end else if (i_fire) begin
            r_phase   <= n_phase;
            r_len     <= n_len;
            r_taken   <= n_taken;
            r_crc     <= n_crc;
            r_carried <= n_carried;
        end
    end

endmodule

// ===== sv/pdc_out_buf.sv =====
module pdc_out_buf
    import pdc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_result   i_data,
    output logic      o_ready,
    pdc_out_if.source o_res
);

    t_result    r_buf [2];
    logic       r_head,  n_head;
    logic [1:0] r_count, n_count;
    logic       pop;
    logic       tail;
    t_result    head_data;

    assign pop       = (r_count != 2'd0) && o_res.ready;
    assign tail      = r_head ^ r_count[0];
    assign o_ready   = (r_count != 2'd2);
    assign head_data = r_buf[r_head];

    assign n_head  = pop ? ~r_head : r_head;
    assign n_count = r_count + {1'b0, i_push} - {1'b0, pop};

    // Drive the result channel from the head entry
    assign o_res.valid          = (r_count != 2'd0);
    assign o_res.is_verdict     = head_data.is_verdict;
    assign o_res.payload_byte   = head_data.payload_byte;
    assign o_res.payload_index  = head_data.payload_index;
    assign o_res.frame_status   = head_data.frame_status;
    assign o_res.received_check = head_data.received_check;
    assign o_res.computed_check = head_data.computed_check;
    assign o_res.frame_length   = head_data.frame_length;

    // Hold pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    // Store a new result at the tail
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[tail] <= i_data;
        end
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import pdc_pkg::*;

    // Quiet cycles allowed before the run is declared hung
    localparam int QUIET_LIMIT   = 4000;
    // Cycles to wait after the last expected result has been seen
    localparam int SETTLE_CYCLES = 8;
    localparam int REPORT_MAX    = 10;

    logic i_clk = 1'b0;
    logic i_rst_n;

    pdc_in_if  rx_ch ();
    pdc_out_if res_ch ();

    packet_deframer_crc16 dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_ch),
        .o_res   (res_ch)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Traffic shaping, set per test
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;

    // Expected results and bookkeeping
    t_result expected_results[$];
    logic [7:0] payload_bytes[$];
    logic [7:0] frame_bytes[$];
    int fail_count     = 0;
    int bytes_sent     = 0;
    int flushes_sent   = 0;
    int payload_seen   = 0;
    int verdict_tally[3];
    int quiet_cycles   = 0;

    // Deframer state as predicted
    t_phase      fr_phase;
    logic [15:0] fr_len;
    logic [15:0] fr_taken;
    logic [15:0] fr_crc;
    logic [15:0] fr_carried;

    // CRC-16, polynomial 0x1021, one data bit at a time, MSB first
    function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] d);
        logic [15:0] acc;
        logic        fb;
        acc = c;
        for (int i = 7; i >= 0; i--) begin
            fb  = acc[15] ^ d[i];
            acc = {acc[14:0], 1'b0};
            if (fb) begin
                acc = acc ^ CRC_POLY;
            end
        end
        return acc;
    endfunction

    function automatic void clear_frame_state();
        fr_phase   = PH_HUNT;
        fr_len     = '0;
        fr_taken   = '0;
        fr_crc     = '0;
        fr_carried = '0;
    endfunction

    function automatic void begin_payload();
        fr_phase = (fr_len == 16'h0000) ? PH_CRC_HI : PH_PAYLOAD;
        fr_taken = '0;
        fr_crc   = '0;
    endfunction

    // Advance the predicted deframer by one transferred byte
    function automatic void advance_deframer(input logic [7:0] b, input logic fl);
        t_result r;
        r = '0;
        if (fl) begin
            clear_frame_state();
            return;
        end
        case (fr_phase)
            PH_HUNT: begin
                if (b == START_SHORT) begin
                    fr_phase = PH_LEN_ONE;
                end else if (b == START_LONG) begin
                    fr_phase = PH_LEN_HI;
                end
            end
            PH_LEN_ONE: begin
                fr_len = {8'h00, b};
                begin_payload();
            end
            PH_LEN_HI: begin
                fr_len   = {b, 8'h00};
                fr_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                fr_len[7:0] = b;
                begin_payload();
            end
            PH_PAYLOAD: begin
                r.payload_byte  = b;
                r.payload_index = fr_taken;
                r.frame_length  = fr_len;
                expected_results.push_back(r);
                payload_seen++;
                fr_crc   = crc_step(fr_crc, b);
                fr_taken = fr_taken + 16'd1;
                if (fr_taken == fr_len) begin
                    fr_phase = PH_CRC_HI;
                end
            end
            PH_CRC_HI: begin
                fr_carried = {b, 8'h00};
                fr_phase   = PH_CRC_LO;
            end
            PH_CRC_LO: begin
                fr_carried[7:0] = b;
                fr_phase        = PH_STOP;
            end
            default: begin
                // Stop byte: a bad stop byte outranks a CRC mismatch
                r.is_verdict = 1'b1;
                if (b != STOP_BYTE) begin
                    r.frame_status = ST_STOP_BAD;
                end else if (fr_carried != fr_crc) begin
                    r.frame_status = ST_CRC_BAD;
                end else begin
                    r.frame_status = ST_GOOD;
                end
                r.received_check = fr_carried;
                r.computed_check = fr_crc;
                r.frame_length   = fr_len;
                expected_results.push_back(r);
                verdict_tally[r.frame_status]++;
                clear_frame_state();
            end
        endcase
    endfunction

    function automatic string show(input t_result r);
        return $sformatf("verdict=%0b byte=%02h idx=%0d status=%0d rx_crc=%04h calc_crc=%04h len=%0d",
                         r.is_verdict, r.payload_byte, r.payload_index, r.frame_status,
                         r.received_check, r.computed_check, r.frame_length);
    endfunction

    // Offer one byte; valid stays high into the next call unless it idles
    task automatic send_item(input logic [7:0] b, input logic fl);
        while ($urandom_range(99) < send_idle_pct) begin
            rx_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        rx_ch.flush   <= fl;
        do @(posedge i_clk); while (!rx_ch.ready);
        advance_deframer(b, fl);
        if (fl) begin
            flushes_sent++;
        end else begin
            bytes_sent++;
        end
    endtask

    // Drop valid and hold until every expected result has been seen
    task automatic wait_drained();
        rx_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic void fill_payload(input int n);
        payload_bytes.delete();
        repeat (n) payload_bytes.push_back(8'($urandom));
    endfunction

    // Wrap the payload in header, CRC (optionally corrupted) and stop byte
    function automatic void compose_frame(input logic long_hdr, input logic [15:0] crc_flip,
                                          input logic [7:0] stop_val);
        logic [15:0] len;
        logic [15:0] crc;
        len = 16'(payload_bytes.size());
        crc = '0;
        frame_bytes.delete();
        if (long_hdr) begin
            frame_bytes.push_back(START_LONG);
            frame_bytes.push_back(len[15:8]);
        end else begin
            frame_bytes.push_back(START_SHORT);
        end
        frame_bytes.push_back(len[7:0]);
        foreach (payload_bytes[i]) begin
            frame_bytes.push_back(payload_bytes[i]);
            crc = crc_step(crc, payload_bytes[i]);
        end
        crc = crc ^ crc_flip;
        frame_bytes.push_back(crc[15:8]);
        frame_bytes.push_back(crc[7:0]);
        frame_bytes.push_back(stop_val);
    endfunction

    task automatic send_bytes(input int n);
        for (int i = 0; i < n; i++) begin
            send_item(frame_bytes[i], 1'b0);
        end
    endtask

    // Mostly well-formed frame with random content, sometimes cut short by a flush
    task automatic send_random_frame();
        int          len;
        logic        long_hdr;
        logic [15:0] flip;
        logic [7:0]  stop_val;
        len      = ($urandom_range(19) == 0) ? $urandom_range(200, 13) : $urandom_range(12);
        long_hdr = (len > 255) ? 1'b1 : 1'($urandom_range(1));
        flip     = ($urandom_range(4) == 0) ? 16'($urandom_range(65535, 1)) : 16'h0000;
        stop_val = ($urandom_range(6) == 0) ? 8'($urandom) : STOP_BYTE;
        fill_payload(len);
        compose_frame(long_hdr, flip, stop_val);
        if ($urandom_range(15) == 0) begin
            send_bytes($urandom_range(frame_bytes.size() - 1, 1));
            send_item(8'($urandom), 1'b1);
        end else begin
            send_bytes(frame_bytes.size());
        end
    endtask

    // Line noise while hunting; flush after a stray start byte to stay aligned
    task automatic send_noise();
        logic [7:0] b;
        repeat ($urandom_range(4, 1)) begin
            b = 8'($urandom);
            send_item(b, 1'b0);
            if (b == START_SHORT || b == START_LONG || $urandom_range(5) == 0) begin
                send_item(8'($urandom), 1'b1);
            end
        end
    endtask

    // Announce a huge length, pass a few bytes, then abandon the frame
    task automatic send_huge_cut();
        send_item(START_LONG, 1'b0);
        send_item(($urandom_range(3) == 0) ? 8'hFF : 8'($urandom_range(255, 1)), 1'b0);
        send_item(($urandom_range(3) == 0) ? 8'hFF : 8'($urandom), 1'b0);
        repeat ($urandom_range(6, 1)) send_item(8'($urandom), 1'b0);
        send_item(8'($urandom), 1'b1);
    endtask

    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // Noise and a flush while hunting
        send_item(8'hFF, 1'b0);
        send_item(8'h00, 1'b1);
        // Zero length with a wrong carried CRC
        payload_bytes.delete();
        compose_frame(1'b0, 16'h1234, STOP_BYTE);
        send_bytes(frame_bytes.size());
        // Two-byte length, extreme payload values, good frame
        payload_bytes.delete();
        payload_bytes.push_back(8'hFF);
        payload_bytes.push_back(8'h00);
        compose_frame(1'b1, 16'h0000, STOP_BYTE);
        send_bytes(frame_bytes.size());
        // Good CRC but bad stop byte
        payload_bytes.delete();
        payload_bytes.push_back(8'h55);
        compose_frame(1'b0, 16'h0000, 8'hFF);
        send_bytes(frame_bytes.size());
        // Flush in the middle of a payload
        send_item(START_SHORT, 1'b0);
        send_item(8'h05, 1'b0);
        send_item(8'hAA, 1'b0);
        send_item(8'hFF, 1'b1);
        wait_drained();
    endtask

    task automatic test_random_traffic(input int snd_pct, input int rcv_pct, input int n_bytes);
        int stop_at;
        int pick;
        send_idle_pct  = snd_pct;
        recv_stall_pct = rcv_pct;
        stop_at        = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 82) begin
                send_random_frame();
            end else if (pick < 94) begin
                send_noise();
            end else begin
                send_huge_cut();
            end
        end
        wait_drained();
    endtask

    // Long receiver hold-off while bytes keep coming: the buffer fills and input stalls
    task automatic test_output_stall();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 300;
        fill_payload(60);
        compose_frame(1'b0, 16'h0000, STOP_BYTE);
        send_bytes(frame_bytes.size());
        wait_drained();
    endtask

    // Result side ready, with random stalls and an occasional long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            res_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else begin
            res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_result seen;
        t_result want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            seen.is_verdict     = res_ch.is_verdict;
            seen.payload_byte   = res_ch.payload_byte;
            seen.payload_index  = res_ch.payload_index;
            seen.frame_status   = t_status'(res_ch.frame_status);
            seen.received_check = res_ch.received_check;
            seen.computed_check = res_ch.computed_check;
            seen.frame_length   = res_ch.frame_length;
            if (expected_results.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_MAX) begin
                    $display("%0t unexpected result: %s", $realtime, show(seen));
                end
            end else begin
                want = expected_results.pop_front();
                if (seen !== want) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX) begin
                        $display("%0t mismatch\n  expected %s\n  actual   %s",
                                 $realtime, show(want), show(seen));
                    end
                end
            end
        end
    end

    // Watchdog: count cycles without any transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Timeout after %0d cycles without a transfer", quiet_cycles);
                $display("Verification failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = 8'h00;
        rx_ch.flush   = 1'b0;
        res_ch.ready  = 1'b0;
        clear_frame_state();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_traffic(24, 78, 210);
        test_random_traffic(78, 24, 210);
        test_random_traffic(0, 0, 210);
        test_output_stall();

        // Anything still outstanding is a failure
        if (expected_results.size() != 0) begin
            fail_count += expected_results.size();
            $display("%0d expected results never arrived", expected_results.size());
        end

        $display("Sent %0d bytes and %0d flushes; checked %0d payload bytes",
                 bytes_sent, flushes_sent, payload_seen);
        $display("Frame verdicts: %0d good, %0d CRC mismatch, %0d bad stop byte",
                 verdict_tally[ST_GOOD], verdict_tally[ST_CRC_BAD], verdict_tally[ST_STOP_BAD]);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
